>>> hdl/rwg_pkg.sv
package rwg_pkg;

  localparam int MG_W   = 13;
  localparam int RAW_W  = 16;
  localparam int PROD_W = 27;
  localparam int SUM_W  = 15;

  localparam logic signed [PROD_W-1:0] MG_SCALE   = 27'sd1000;
  localparam logic signed [PROD_W-1:0] LSB_ROUND  = 27'sd8191;
  localparam int                       LSB_SHIFT  = 13;
  localparam logic [SUM_W-1:0]         GRAVITY_MIN = 15'd600;
  localparam logic [SUM_W-1:0]         GRAVITY_MAX = 15'd1900;
  localparam logic signed [MG_W-1:0]   Y_NEG_LIMIT = -13'sd80;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  localparam logic [2:0] CFG_WARMUP_SAMPLES = 3'd0;
  localparam logic [2:0] CFG_MIN_ARM_MOTION = 3'd1;
  localparam logic [2:0] CFG_MIN_Z_RISE     = 3'd2;
  localparam logic [2:0] CFG_FACE_MIN_Z     = 3'd3;
  localparam logic [2:0] CFG_STABLE_DELTA   = 3'd4;
  localparam logic [2:0] CFG_Y_DROP_MIN     = 3'd5;
  localparam logic [2:0] CFG_POSE_DELTA_MIN = 3'd6;
  localparam logic [2:0] CFG_STABLE_SAMPLES = 3'd7;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_SAMPLE,
    KIND_END,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   sample_valid;
    logic signed [MG_W-1:0] x_mg;
    logic signed [MG_W-1:0] y_mg;
    logic signed [MG_W-1:0] z_mg;
  } req_t;

  function automatic logic [MG_W-1:0] abs14(input logic signed [MG_W:0] v);
    logic signed [MG_W:0] n;
    n = -v;
    return v[MG_W] ? n[MG_W-1:0] : v[MG_W-1:0];
  endfunction

endpackage

>>> hdl/rwg_front.sv
module rwg_front
  import rwg_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        q_full,
  output logic        push,
  output req_t        push_req
);

  logic signed [RAW_W-1:0] raw [3];
  logic signed [MG_W-1:0]  mg  [3];
  logic [1:0]              op;
  logic                    valid;

  function automatic logic signed [MG_W-1:0] to_mg(input logic signed [RAW_W-1:0] r);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] adj;
    prod = PROD_W'(r) * MG_SCALE;
    adj  = prod[PROD_W-1] ? prod + LSB_ROUND : prod;
    return adj[LSB_SHIFT+MG_W-1:LSB_SHIFT];
  endfunction

  assign raw[0] = in_tdata[15:0];
  assign raw[1] = in_tdata[31:16];
  assign raw[2] = in_tdata[47:32];
  assign op     = in_tuser[1:0];
  assign valid  = in_tuser[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i] = valid ? to_mg(raw[i]) : '0;
    end
  end

  always_comb begin
    unique case (op)
      OP_BEGIN:  push_req.kind = KIND_BEGIN;
      OP_SAMPLE: push_req.kind = KIND_SAMPLE;
      OP_END:    push_req.kind = KIND_END;
      default:   push_req.kind = KIND_NONE;
    endcase
    push_req.sample_valid = valid;
    push_req.x_mg         = mg[0];
    push_req.y_mg         = mg[1];
    push_req.z_mg         = mg[2];
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

endmodule

>>> hdl/rwg_queue.sv
module rwg_queue
  import rwg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output req_t head,
  output logic nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> hdl/rwg_back.sv
module rwg_back
  import rwg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        q_nonempty,
  input  req_t        head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata
);

  logic [7:0]             warmup_samples_r;
  logic [SUM_W-1:0]       min_arm_motion_r;
  logic [MG_W-1:0]        min_z_rise_r;
  logic signed [MG_W-1:0] face_min_z_r;
  logic [SUM_W-1:0]       stable_delta_r;
  logic [MG_W-1:0]        y_drop_min_r;
  logic [SUM_W-1:0]       pose_delta_min_r;
  logic [7:0]             stable_samples_r;

  logic                   armed_r, armed_nxt;
  logic                   motion_r, motion_nxt;
  logic [7:0]             warm_r, warm_nxt;
  logic [7:0]             run_r, run_nxt;
  logic signed [MG_W-1:0] base_r [3];
  logic signed [MG_W-1:0] base_nxt [3];
  logic signed [MG_W-1:0] prev_r [3];
  logic signed [MG_W-1:0] prev_nxt [3];

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [47:0]            out_tdata_r, out_tdata_nxt;

  logic signed [MG_W-1:0] ax [3];
  logic [SUM_W-1:0]       frame, pose, total;
  logic signed [MG_W:0]   z_rise, y_drop;
  logic                   gravity, face, stable, qual, wake;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign pop        = q_nonempty && (!out_tvalid_r || out_tready);

  assign ax[0] = head.x_mg;
  assign ax[1] = head.y_mg;
  assign ax[2] = head.z_mg;

  always_comb begin
    frame = '0;
    pose  = '0;
    total = '0;
    for (int i = 0; i < 3; i++) begin
      frame = frame + SUM_W'(abs14({ax[i][MG_W-1], ax[i]} - {prev_r[i][MG_W-1], prev_r[i]}));
      pose  = pose + SUM_W'(abs14({ax[i][MG_W-1], ax[i]} - {base_r[i][MG_W-1], base_r[i]}));
      total = total + SUM_W'(abs14({ax[i][MG_W-1], ax[i]}));
    end
    z_rise = {ax[2][MG_W-1], ax[2]} - {base_r[2][MG_W-1], base_r[2]};
    y_drop = {base_r[1][MG_W-1], base_r[1]} - {ax[1][MG_W-1], ax[1]};
  end

  always_comb begin
    armed_nxt  = armed_r;
    motion_nxt = motion_r;
    warm_nxt   = warm_r;
    run_nxt    = run_r;
    base_nxt   = base_r;
    prev_nxt   = prev_r;
    gravity    = (total >= GRAVITY_MIN) && (total <= GRAVITY_MAX);
    face       = (ax[2] >= face_min_z_r)
              && ((z_rise >= $signed({1'b0, min_z_rise_r}))
               || (y_drop >= $signed({1'b0, y_drop_min_r}))
               || (ax[1] <= Y_NEG_LIMIT)
               || (pose >= pose_delta_min_r));
    stable     = (frame <= stable_delta_r);
    qual       = 1'b0;
    wake       = 1'b0;
    unique case (head.kind)
      KIND_BEGIN: begin
        armed_nxt  = head.sample_valid;
        motion_nxt = 1'b0;
        warm_nxt   = warmup_samples_r;
        run_nxt    = '0;
        if (head.sample_valid) begin
          base_nxt = ax;
          prev_nxt = ax;
        end
      end
      KIND_SAMPLE: begin
        if (armed_r && head.sample_valid) begin
          prev_nxt = ax;
          if (warm_r != '0) begin
            base_nxt = ax;
            warm_nxt = warm_r - 1'b1;
          end else begin
            motion_nxt = motion_r || (frame >= min_arm_motion_r)
                      || (pose >= pose_delta_min_r);
            qual = motion_nxt && gravity && face && stable;
            if (qual) begin
              run_nxt = (run_r == 8'hFF) ? run_r : run_r + 1'b1;
              wake    = (run_nxt >= stable_samples_r);
            end else begin
              run_nxt = '0;
            end
          end
        end
      end
      KIND_END: begin
        armed_nxt  = 1'b0;
        motion_nxt = 1'b0;
        run_nxt    = '0;
      end
      KIND_NONE: begin
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (pop) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {7'd0, ax[2], ax[1], ax[0], armed_nxt, wake};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_samples_r <= 8'd6;
      min_arm_motion_r <= 15'd160;
      min_z_rise_r     <= 13'd100;
      face_min_z_r     <= 13'sd650;
      stable_delta_r   <= 15'd450;
      y_drop_min_r     <= 13'd380;
      pose_delta_min_r <= 15'd430;
      stable_samples_r <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WARMUP_SAMPLES: warmup_samples_r <= cfg_data[7:0];
        CFG_MIN_ARM_MOTION: min_arm_motion_r <= cfg_data;
        CFG_MIN_Z_RISE:     min_z_rise_r     <= cfg_data[12:0];
        CFG_FACE_MIN_Z:     face_min_z_r     <= cfg_data[12:0];
        CFG_STABLE_DELTA:   stable_delta_r   <= cfg_data;
        CFG_Y_DROP_MIN:     y_drop_min_r     <= cfg_data[12:0];
        CFG_POSE_DELTA_MIN: pose_delta_min_r <= cfg_data;
        CFG_STABLE_SAMPLES: stable_samples_r <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      motion_r     <= 1'b0;
      warm_r       <= '0;
      run_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        base_r[i] <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (pop) begin
        armed_r  <= armed_nxt;
        motion_r <= motion_nxt;
        warm_r   <= warm_nxt;
        run_r    <= run_nxt;
        base_r   <= base_nxt;
        prev_r   <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

>>> hdl/raise_wrist_gesture_detector.sv
// A request is written into the queue and then, when popped, into the output register.
// Throughput: one request per cycle while out_tready stays high, set by the back-end state update;
// an output stall holds QUEUE_DEPTH queued requests plus one in the output register.
// Reset (rst_n, synchronous, active low) empties the queue, disarms the
// detector, clears its state and loads the register defaults.
module raise_wrist_gesture_detector
  import rwg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  input  logic [2:0]  in_tuser,   // operation[1:0], sample_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // wake, detecting, x_mg, y_mg, z_mg, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  logic push, pop, q_full, q_nonempty;
  req_t push_req, head;

  rwg_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_req  (push_req)
  );

  rwg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty)
  );

  rwg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hdl/rwg_checker.sv
module rwg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_wake_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && !out_tdata[1]))
    else $error("wake without detecting");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("request produced no result");

  a_mg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:2]) >= -13'sd4000)
               && ($signed(out_tdata[27:15]) >= -13'sd4000)
               && ($signed(out_tdata[40:28]) >= -13'sd4000))
    else $error("converted axis out of range");

endmodule

bind raise_wrist_gesture_detector rwg_checker u_rwg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rwg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'(KIND_NONE);

  typedef struct packed {
    logic signed [MG_W-1:0] z_mg;
    logic signed [MG_W-1:0] y_mg;
    logic signed [MG_W-1:0] x_mg;
    logic                   detecting;
    logic                   wake;
  } reading_t;

  typedef struct packed {
    logic     on;
    reading_t val;
  } pin_t;

  typedef struct {
    int warm, arm, zr, fz, sd, yd, pd, ss;
  } knobs_t;

  typedef struct {
    logic [1:0]  op;
    logic        vld;
    logic [15:0] x, y, z;
    pin_t        pin;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // raw_x, raw_y, raw_z
  logic [2:0]  in_tuser = '0;   // operation[1:0], sample_valid
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // wake, detecting, x_mg, y_mg, z_mg, zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  raise_wrist_gesture_detector uut (.*);

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // detector copy
  int warm_cfg, arm_cfg, zr_cfg, fz_cfg, sd_cfg, yd_cfg, pd_cfg, ss_cfg;
  bit armed_q, motion_q;
  int warm_left, run_len;
  int base_mg[3], prev_mg[3];

  reading_t pending_readings[$];
  pin_t     pinned_readings[$];
  int       items_sent = 0, results_seen = 0, wakes_seen = 0, errors = 0;
  bit       send_idle = 1'b0, rcv_idle = 1'b0;
  knobs_t   cur;
  int       stall_left = 0;

  function automatic int to_mg(logic [15:0] raw);
    return ($signed(raw) * 1000) / 8192;
  endfunction

  function automatic int mag(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic reading_t next_reading(logic [1:0] op, logic vld, logic [47:0] d);
    int ax[3];
    int frame, pose, total;
    bit gravity, face, steady;
    reading_t r;
    r = '0;
    for (int i = 0; i < 3; i++) ax[i] = vld ? to_mg(d[16*i +: 16]) : 0;
    if (op == OP_BEGIN) begin
      armed_q = 0;
      motion_q = 0;
      warm_left = warm_cfg;
      run_len = 0;
      if (vld) begin
        base_mg = ax;
        prev_mg = ax;
        armed_q = 1;
      end
    end else if (op == OP_SAMPLE && armed_q && vld) begin
      if (warm_left > 0) begin
        base_mg = ax;
        prev_mg = ax;
        warm_left--;
      end else begin
        frame = 0;
        pose = 0;
        total = 0;
        for (int i = 0; i < 3; i++) begin
          frame += mag(ax[i] - prev_mg[i]);
          pose += mag(ax[i] - base_mg[i]);
          total += mag(ax[i]);
        end
        prev_mg = ax;
        if (frame >= arm_cfg || pose >= pd_cfg) motion_q = 1;
        gravity = total >= int'(GRAVITY_MIN) && total <= int'(GRAVITY_MAX);
        face = ax[2] >= fz_cfg && (ax[2] - base_mg[2] >= zr_cfg ||
                                   base_mg[1] - ax[1] >= yd_cfg ||
                                   ax[1] <= int'(Y_NEG_LIMIT) || pose >= pd_cfg);
        steady = frame <= sd_cfg;
        if (motion_q && gravity && face && steady) begin
          if (run_len < 255) run_len++;
          r.wake = run_len >= ss_cfg;
        end else begin
          run_len = 0;
        end
      end
    end else if (op == OP_END) begin
      armed_q = 0;
      motion_q = 0;
      run_len = 0;
    end
    r.detecting = armed_q;
    r.x_mg = MG_W'(ax[0]);
    r.y_mg = MG_W'(ax[1]);
    r.z_mg = MG_W'(ax[2]);
    return r;
  endfunction

  task automatic clear_detector();
    warm_cfg = 6;
    arm_cfg = 160;
    zr_cfg = 100;
    fz_cfg = 650;
    sd_cfg = 450;
    yd_cfg = 380;
    pd_cfg = 430;
    ss_cfg = 1;
    armed_q = 0;
    motion_q = 0;
    warm_left = 0;
    run_len = 0;
    base_mg = '{0, 0, 0};
    prev_mg = '{0, 0, 0};
  endtask

  task automatic write_knob(logic [2:0] idx, logic [14:0] v);
    case (idx)
      CFG_WARMUP_SAMPLES: warm_cfg = v[7:0];
      CFG_MIN_ARM_MOTION: arm_cfg = v;
      CFG_MIN_Z_RISE:     zr_cfg = v[12:0];
      CFG_FACE_MIN_Z:     fz_cfg = $signed(v[12:0]);
      CFG_STABLE_DELTA:   sd_cfg = v;
      CFG_Y_DROP_MIN:     yd_cfg = v[12:0];
      CFG_POSE_DELTA_MIN: pd_cfg = v;
      CFG_STABLE_SAMPLES: ss_cfg = v[7:0];
      default: ;
    endcase
  endtask

  task automatic flag(string what, reading_t want, reading_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: want wake=%0b det=%0b x=%0d y=%0d z=%0d, got wake=%0b det=%0b x=%0d y=%0d z=%0d pad=%h",
               $realtime, what, want.wake, want.detecting, want.x_mg, want.y_mg, want.z_mg,
               got.wake, got.detecting, got.x_mg, got.y_mg, got.z_mg, out_tdata[47:41]);
  endtask

  always @(posedge clk) begin : monitor
    reading_t got, want;
    pin_t p;
    if (!rst_n) begin
      clear_detector();
      pending_readings.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[40:0];
        results_seen++;
        if (got.wake === 1'b1) wakes_seen++;
        if (pending_readings.size() == 0) begin
          flag("result with no request pending", '0, got);
        end else begin
          want = pending_readings.pop_front();
          if (got.wake !== want.wake || got.detecting !== want.detecting ||
              got.x_mg !== want.x_mg || got.y_mg !== want.y_mg ||
              got.z_mg !== want.z_mg || out_tdata[47:41] !== '0)
            flag("mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) write_knob(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        want = next_reading(in_tuser[1:0], in_tuser[2], in_tdata);
        p = pinned_readings.pop_front();
        pending_readings.push_back(p.on ? p.val : want);
      end
    end
  end

  function automatic int pause_len(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pause_len(rcv_idle);
      out_tready <= (stall_left == 0);
    end
  end

  function automatic int jit(int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  function automatic logic [15:0] to_raw(int mg);
    return 16'((mg * 8192) / 1000 + int'($urandom_range(0, 6)));
  endfunction

  function automatic step_t row(logic [1:0] op, logic vld, int x, int y, int z,
                                bit pin = 0, bit w = 0, bit det = 0,
                                int xm = 0, int ym = 0, int zm = 0);
    step_t s;
    s.op = op;
    s.vld = vld;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    s.pin.on = pin;
    s.pin.val.wake = w;
    s.pin.val.detecting = det;
    s.pin.val.x_mg = MG_W'(xm);
    s.pin.val.y_mg = MG_W'(ym);
    s.pin.val.z_mg = MG_W'(zm);
    return s;
  endfunction

  task automatic send(logic [1:0] op, logic vld, logic [15:0] x, logic [15:0] y,
                      logic [15:0] z, pin_t pin = '0);
    int g;
    g = pause_len(send_idle);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pinned_readings.push_back(pin);
    in_tvalid <= 1'b1;
    in_tuser <= {vld, op};
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold off new requests until every pending result is back
  task automatic settle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while ((pending_readings.size() > 0 || pinned_readings.size() > 0) && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 15'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_knobs(knobs_t k);
    cur = k;
    put_reg(CFG_WARMUP_SAMPLES, k.warm);
    put_reg(CFG_MIN_ARM_MOTION, k.arm);
    put_reg(CFG_MIN_Z_RISE, k.zr);
    put_reg(CFG_FACE_MIN_Z, k.fz);
    put_reg(CFG_STABLE_DELTA, k.sd);
    put_reg(CFG_Y_DROP_MIN, k.yd);
    put_reg(CFG_POSE_DELTA_MIN, k.pd);
    put_reg(CFG_STABLE_SAMPLES, k.ss);
    cfg_valid <= 1'b0;
  endtask

  // begin, warm-up, swing toward the face, hold, usually end
  task automatic gesture(int hold_lo, int hold_hi, bit rough);
    int bx, by, bz, fx, fy, fz, n, steps, sel;
    logic [15:0] rx, ry, rz;
    bx = jit(300);
    by = $urandom_range(0, 1000);
    bz = jit(300);
    fx = jit(200);
    fy = int'($urandom_range(0, 500)) - 300;
    fz = $urandom_range(700, 1000);
    send(OP_BEGIN, rough ? ($urandom_range(0, 9) != 0) : 1'b1,
         to_raw(bx), to_raw(by), to_raw(bz));
    n = cur.warm;
    if (n > 0 && $urandom_range(0, 4) == 0) n = $urandom_range(0, n - 1);
    repeat (n) send(OP_SAMPLE, 1'b1, to_raw(bx + jit(20)), to_raw(by + jit(20)),
                    to_raw(bz + jit(20)));
    steps = $urandom_range(1, 4);
    for (int i = 1; i <= steps; i++)
      send(OP_SAMPLE, 1'b1, to_raw(bx + (fx - bx) * i / steps),
           to_raw(by + (fy - by) * i / steps), to_raw(bz + (fz - bz) * i / steps));
    n = $urandom_range(hold_lo, hold_hi);
    rx = to_raw(fx);
    ry = to_raw(fy);
    rz = to_raw(fz);
    repeat (n) begin
      sel = $urandom_range(0, 39);
      if (sel == 2 && !rough) sel = 3;
      case (sel)
        0: send(OP_SAMPLE, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        1: send(OP_UNUSED, 1'b1, rx, ry, rz);
        2: send(OP_SAMPLE, 1'b1, to_raw(jit(2000)), to_raw(jit(2000)), to_raw(jit(2000)));
        default: begin
          if ($urandom_range(0, 1) != 0) begin
            rx = to_raw(fx + jit(20));
            ry = to_raw(fy + jit(20));
            rz = to_raw(fz + jit(20));
          end
          send(OP_SAMPLE, 1'b1, rx, ry, rz);
        end
      endcase
    end
    if ($urandom_range(0, 4) != 0)
      send(OP_END, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic run_phase(knobs_t k, int budget, int hold_lo, int hold_hi, bit rough);
    int start;
    settle();
    load_knobs(k);
    start = items_sent;
    while (items_sent - start < budget) begin
      if (rough && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        gesture(hold_lo, hold_hi, rough);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        rcv_idle = $urandom_range(0, 2) != 0;
      end
    end
    settle();
  endtask

  initial begin : stimulus
    step_t steps[$];
    knobs_t k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 1;
    rcv_idle = 1;
    load_knobs('{1, 160, 100, 650, 450, 380, 430, 1});

    steps.push_back(row(OP_SAMPLE, 1, 32767, -32768, 0, 1, 0, 0, 3999, -4000, 0));
    steps.push_back(row(OP_END, 0, -1, -1, -1, 1, 0, 0, 0, 0, 0));
    steps.push_back(row(OP_UNUSED, 1, -1, 1, 8192, 1, 0, 0, 0, 0, 1000));
    steps.push_back(row(OP_BEGIN, 0, 1000, 1000, 1000, 1, 0, 0, 0, 0, 0));
    steps.push_back(row(OP_SAMPLE, 1, 8192, 8192, 8192, 1, 0, 0, 1000, 1000, 1000));
    steps.push_back(row(OP_BEGIN, 1, 0, 8192, 0, 1, 0, 1, 0, 1000, 0));
    steps.push_back(row(OP_SAMPLE, 1, 0, 8192, 0, 1, 0, 1, 0, 1000, 0));
    steps.push_back(row(OP_SAMPLE, 0, 4096, 4096, 4096, 1, 0, 1, 0, 0, 0));
    steps.push_back(row(OP_SAMPLE, 1, 0, 4096, 4096));
    steps.push_back(row(OP_SAMPLE, 1, 0, 0, 8192));
    steps.push_back(row(OP_SAMPLE, 1, 0, 0, 8192));
    steps.push_back(row(OP_SAMPLE, 1, 40, -800, 8192));
    steps.push_back(row(OP_UNUSED, 1, 0, 0, 8192));
    steps.push_back(row(OP_SAMPLE, 1, 16384, 0, 8192));
    steps.push_back(row(OP_SAMPLE, 1, 0, 0, 2000));
    steps.push_back(row(OP_END, 1, 0, 0, 8192, 1, 0, 0, 0, 0, 1000));
    steps.push_back(row(OP_SAMPLE, 1, 0, 0, 8192, 1, 0, 0, 0, 0, 1000));
    steps.push_back(row(OP_BEGIN, 1, -32768, -32768, -32768, 1, 0, 1, -4000, -4000, -4000));
    steps.push_back(row(OP_SAMPLE, 1, 32767, 32767, 32767));
    steps.push_back(row(OP_BEGIN, 1, 0, 0, 8192, 1, 0, 1, 0, 0, 1000));
    steps.push_back(row(OP_END, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    foreach (steps[i]) send(steps[i].op, steps[i].vld, steps[i].x, steps[i].y, steps[i].z,
                            steps[i].pin);

    run_phase('{6, 160, 100, 650, 450, 380, 430, 1}, 200, 1, 12, 1);
    run_phase('{0, 0, 0, -4000, 0, 0, 0, 0}, 150, 1, 8, 1);
    // long steady hold so the run counter saturates
    run_phase('{2, 160, 100, 650, 450, 380, 430, 255}, 250, 258, 275, 0);
    run_phase('{255, 24000, 8000, 4000, 24000, 8000, 24000, 255}, 200, 1, 6, 1);
    k.warm = $urandom_range(0, 4);
    k.arm = $urandom_range(0, 600);
    k.zr = $urandom_range(0, 400);
    k.fz = int'($urandom_range(0, 1400)) - 500;
    k.sd = $urandom_range(50, 600);
    k.yd = $urandom_range(0, 600);
    k.pd = $urandom_range(0, 800);
    k.ss = $urandom_range(0, 4);
    run_phase(k, 160, 1, 10, 1);

    if (pending_readings.size() > 0) begin
      $display("%0d results never arrived", pending_readings.size());
      errors += pending_readings.size();
    end
    $display("%0d requests over six register settings (reset values, both extremes, random)",
             items_sent);
    $display("%0d results compared, %0d with wake raised, %0d failures",
             results_seen, wakes_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
